// ----- hdl/sass_pkg.sv -----
// Shared types and constants for the sprite animation script sequencer.
// No dependencies; every other file imports this package.
`default_nettype none

package sass_pkg;

  // Script opcodes
  localparam logic [7:0] OP_PUSH = 8'hF0;
  localparam logic [7:0] OP_LOOP = 8'hF1;
  localparam logic [7:0] OP_JUMP = 8'hF2;
  localparam logic [7:0] OP_END  = 8'hFF;
  localparam logic [7:0] ENDLESS = 8'hFF;

  // Random values are taken modulo this
  localparam logic [6:0] RND_MOD = 7'd100;

  // Input action codes
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_START = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] anim_number;
    logic [7:0] position;
    logic [7:0] script_byte;
    logic [6:0] random_percent;
  } in_item_t;

  typedef struct packed {
    logic signed [8:0] texture_index;
    logic              ended;
    logic [3:0]        current_anim;
    logic              stack_fault;
    logic              runaway;
  } out_item_t;

  // Classified item held in the queue between front and core
  typedef struct packed {
    kind_t      kind;
    logic [3:0] anim;
    logic [7:0] pos;
    logic [7:0] data;
    logic [6:0] rnd;
  } q_item_t;

endpackage

`default_nettype wire

// ----- hdl/sass_front.sv -----
// Front end: accepts input beats, classifies them, reduces the random value
// and holds them in a two-entry queue for the core. Depends on sass_pkg.
`default_nettype none

module sass_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sass_pkg::in_item_t in_item,
  output logic               q_valid,
  input  logic               q_take,
  output sass_pkg::q_item_t  q_item,
  output logic [1:0]         count
);
  import sass_pkg::*;

  q_item_t    ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  q_item_t    cls;
  logic       push, pop;

  always_comb begin
    cls.anim = in_item.anim_number;
    cls.pos  = in_item.position;
    cls.data = in_item.script_byte;
    // 7-bit value stays below twice the modulus
    cls.rnd  = (in_item.random_percent >= RND_MOD) ?
               7'(in_item.random_percent - RND_MOD) : in_item.random_percent;
    case (in_item.action)
      ACT_WRITE: cls.kind = KIND_WRITE;
      ACT_START: cls.kind = KIND_START;
      ACT_TICK:  cls.kind = KIND_TICK;
      default:   cls.kind = KIND_NONE;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_item   = ent_r[rp_r];
  assign count    = cnt_r;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = 2'(cnt_r + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= cls;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sass_core.sv -----
// Back end: script store, loop stack and a walker that executes queued items,
// a script byte per wait and execute pass, into a result register. Uses sass_pkg.
`default_nettype none

module sass_core #(
  parameter int NUM_ANIMS   = 16,
  parameter int SCRIPT_LEN  = 256,
  parameter int STACK_DEPTH = 4,
  parameter int MAX_OPS     = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  sass_pkg::q_item_t                  q_item,
  output logic                               q_take,
  output logic                               out_valid,
  input  logic                               out_ready,
  output sass_pkg::out_item_t                out_item,
  output logic [$clog2(STACK_DEPTH+1)-1:0]   level
);
  import sass_pkg::*;

  localparam int SLOT_W    = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;
  localparam int OFF_W     = $clog2(SCRIPT_LEN);
  localparam int MEM_DEPTH = NUM_ANIMS * SCRIPT_LEN;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int LVL_W     = $clog2(STACK_DEPTH + 1);
  localparam int TOP_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int OPS_W     = $clog2(MAX_OPS + 1);

  function automatic logic [256*SLOT_W-1:0] build_slot_tbl();
    logic [256*SLOT_W-1:0] t;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      t[i*SLOT_W +: SLOT_W] = SLOT_W'(i % NUM_ANIMS);
    end
    return t;
  endfunction

  function automatic logic [256*OFF_W-1:0] build_off_tbl();
    logic [256*OFF_W-1:0] t;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      t[i*OFF_W +: OFF_W] = OFF_W'(i % SCRIPT_LEN);
    end
    return t;
  endfunction

  localparam logic [256*SLOT_W-1:0] SLOT_TBL = build_slot_tbl();
  localparam logic [256*OFF_W-1:0]  OFF_TBL  = build_off_tbl();

  function automatic logic [ADDR_W-1:0] addr_of(input logic [SLOT_W-1:0] s,
                                                input logic [OFF_W-1:0] o);
    return ADDR_W'(ADDR_W'(s) * ADDR_W'(SCRIPT_LEN)) + ADDR_W'(o);
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WR   = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_EXEC = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  q_item_t           item_r, item_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [8:0]        tex_r, tex_nxt;
  logic              parity_r, parity_nxt;
  logic              step_r, step_nxt;
  logic              walking_r, walking_nxt;
  logic              tick_r, tick_nxt;
  logic              fault_r, fault_nxt;
  logic              runaway_r, runaway_nxt;
  logic [OPS_W-1:0]  ops_r, ops_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        rd_op_r, rd_arg_r;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr, ra_op, ra_arg;

  logic [OFF_W-1:0]  stk_ret_r [STACK_DEPTH];
  logic [7:0]        stk_cnt_r [STACK_DEPTH];
  logic              ret_we, cnt_we;
  logic [TOP_W-1:0]  stk_wi, top;
  logic [OFF_W-1:0]  ret_d;
  logic [7:0]        cnt_d, rem, rem_dec;

  logic [OFF_W-1:0]  off_p1, off_p2;
  logic [OFF_W:0]    off_sum2;
  logic              done;

  assign off_p1   = (off_r == OFF_W'(SCRIPT_LEN - 1)) ? '0 : OFF_W'(off_r + 1'b1);
  assign off_sum2 = {1'b0, off_r} + (OFF_W+1)'(2);
  assign off_p2   = (off_sum2 >= (OFF_W+1)'(SCRIPT_LEN)) ?
                    OFF_W'(off_sum2 - (OFF_W+1)'(SCRIPT_LEN)) : OFF_W'(off_sum2);

  assign top     = TOP_W'(lvl_r - 1'b1);
  assign rem     = stk_cnt_r[top];
  assign rem_dec = (rem == ENDLESS) ? rem : 8'(rem - 8'd1);

  assign wr_addr = addr_of(SLOT_TBL[{4'd0, item_r.anim}*SLOT_W +: SLOT_W],
                           OFF_TBL[item_r.pos*OFF_W +: OFF_W]);
  assign ra_op   = addr_of(slot_r, off_r);
  assign ra_arg  = addr_of(slot_r, off_p1);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    slot_nxt      = slot_r;
    off_nxt       = off_r;
    lvl_nxt       = lvl_r;
    tex_nxt       = tex_r;
    parity_nxt    = parity_r;
    step_nxt      = step_r;
    walking_nxt   = walking_r;
    tick_nxt      = tick_r;
    fault_nxt     = fault_r;
    runaway_nxt   = runaway_r;
    ops_nxt       = ops_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    q_take        = 1'b0;
    mem_we        = 1'b0;
    ret_we        = 1'b0;
    cnt_we        = 1'b0;
    stk_wi        = top;
    ret_d         = off_p2;
    cnt_d         = rd_arg_r;
    done          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_take      = 1'b1;
          item_nxt    = q_item;
          ops_nxt     = '0;
          fault_nxt   = 1'b0;
          runaway_nxt = 1'b0;
          walking_nxt = 1'b0;
          tick_nxt    = 1'b0;
          state_nxt   = ST_WAIT;
          case (q_item.kind)
            KIND_WRITE: begin
              state_nxt = ST_WR;
            end
            KIND_START: begin
              slot_nxt    = SLOT_TBL[{4'd0, q_item.anim}*SLOT_W +: SLOT_W];
              off_nxt     = '0;
              lvl_nxt     = '0;
              tex_nxt     = 9'h1FF;
              parity_nxt  = 1'b0;
              step_nxt    = 1'b0;
              walking_nxt = 1'b1;
            end
            KIND_TICK: begin
              step_nxt    = parity_r;
              walking_nxt = 1'b1;
              tick_nxt    = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_WR: begin
        mem_we    = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!walking_r) begin
          done = 1'b1;
        end else if (ops_r == OPS_W'(MAX_OPS)) begin
          runaway_nxt = 1'b1;
          done        = 1'b1;
        end else if (rd_op_r == OP_END) begin
          done = 1'b1;
        end else if (rd_op_r == OP_PUSH) begin
          ops_nxt   = OPS_W'(ops_r + 1'b1);
          off_nxt   = off_p2;
          state_nxt = ST_WAIT;
          if (lvl_r == LVL_W'(STACK_DEPTH)) begin
            fault_nxt = 1'b1;
          end else begin
            stk_wi  = TOP_W'(lvl_r);
            ret_we  = 1'b1;
            cnt_we  = 1'b1;
            lvl_nxt = LVL_W'(lvl_r + 1'b1);
          end
        end else if (rd_op_r == OP_LOOP) begin
          ops_nxt   = OPS_W'(ops_r + 1'b1);
          state_nxt = ST_WAIT;
          if (lvl_r == '0) begin
            fault_nxt = 1'b1;
            off_nxt   = off_p2;
          end else begin
            cnt_we = 1'b1;
            cnt_d  = rem_dec;
            if (rem_dec != 8'd0 && rd_arg_r > {1'b0, item_r.rnd}) begin
              off_nxt = stk_ret_r[top];
            end else begin
              off_nxt = off_p2;
              lvl_nxt = LVL_W'(lvl_r - 1'b1);
            end
          end
        end else if (rd_op_r == OP_JUMP) begin
          ops_nxt   = OPS_W'(ops_r + 1'b1);
          off_nxt   = '0;
          slot_nxt  = SLOT_TBL[rd_arg_r*SLOT_W +: SLOT_W];
          lvl_nxt   = '0;
          state_nxt = ST_WAIT;
        end else begin
          // Frame byte: show it, then either stop or step past it once
          tex_nxt = 9'({1'b0, rd_op_r} - 9'd1);
          if (!step_r) begin
            done = 1'b1;
          end else begin
            ops_nxt   = OPS_W'(ops_r + 1'b1);
            off_nxt   = off_p1;
            step_nxt  = 1'b0;
            state_nxt = ST_WAIT;
          end
        end

        if (done) begin
          state_nxt = ST_EXEC;
          // Hold here until the result register frees up
          if (!out_valid_r || out_ready) begin
            out_valid_nxt              = 1'b1;
            out_item_nxt.texture_index = $signed(tex_nxt);
            out_item_nxt.ended         = (rd_op_r == OP_END);
            out_item_nxt.current_anim  = 4'(slot_r);
            out_item_nxt.stack_fault   = fault_nxt;
            out_item_nxt.runaway       = runaway_nxt;
            if (tick_r) begin
              parity_nxt = ~parity_r;
            end
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      off_r       <= '0;
      lvl_r       <= '0;
      tex_r       <= 9'h1FF;
      parity_r    <= 1'b0;
      step_r      <= 1'b0;
      walking_r   <= 1'b0;
      tick_r      <= 1'b0;
      fault_r     <= 1'b0;
      runaway_r   <= 1'b0;
      ops_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      off_r       <= off_nxt;
      lvl_r       <= lvl_nxt;
      tex_r       <= tex_nxt;
      parity_r    <= parity_nxt;
      step_r      <= step_nxt;
      walking_r   <= walking_nxt;
      tick_r      <= tick_nxt;
      fault_r     <= fault_nxt;
      runaway_r   <= runaway_nxt;
      ops_r       <= ops_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_item_r <= out_item_nxt;
  end

  // Script store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= item_r.data;
    end
    rd_op_r  <= mem[ra_op];
    rd_arg_r <= mem[ra_arg];
  end

  always_ff @(posedge clk) begin
    if (ret_we) begin
      stk_ret_r[stk_wi] <= ret_d;
    end
    if (cnt_we) begin
      stk_cnt_r[stk_wi] <= cnt_d;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign level     = lvl_r;

endmodule

`default_nettype wire

// ----- hdl/sprite_animation_script_sequencer.sv -----
// Top level of the sprite animation script sequencer: front queue plus core.
// Depends on sass_pkg, sass_front and sass_core.
//
//   Channel  Ports                          Beat
//   input    in_valid / in_ready / in_item  write, start or tick item
//   result   out_valid / out_ready / out_item  one result per input item
//
// Items queue two deep in front of the core, so the input side keeps taking
// beats while the core walks a script or a result waits to be taken.
// The core handles one item at a time: a write passes the write, wait and
// execute states, others wait and execute, a start or tick repeating them
// per byte visited, capped by MAX_OPS; each visited byte costs a registered
// store read. Reset is synchronous; the store is not cleared and holds
// garbage until written. A full result register stalls the core in place.
`default_nettype none

module sprite_animation_script_sequencer #(
  parameter int NUM_ANIMS   = 16,
  parameter int SCRIPT_LEN  = 256,
  parameter int STACK_DEPTH = 4,
  parameter int MAX_OPS     = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sass_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output sass_pkg::out_item_t out_item
);
  import sass_pkg::*;

  q_item_t                            q_item;
  logic                               q_valid;
  logic                               q_take;
  logic [1:0]                         q_count;
  logic [$clog2(STACK_DEPTH+1)-1:0]   level;

  sass_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_take   (q_take),
    .q_item   (q_item),
    .count    (q_count)
  );

  sass_core #(
    .NUM_ANIMS   (NUM_ANIMS),
    .SCRIPT_LEN  (SCRIPT_LEN),
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_OPS     (MAX_OPS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .level     (level)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count != 2'd3)
    else $error("queue count out of range");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= ($clog2(STACK_DEPTH+1))'(STACK_DEPTH))
    else $error("loop stack level beyond depth");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && q_count == 2'd0) |=> (q_count == 2'd1))
    else $error("accepted beat lost from empty queue");

endmodule

`default_nettype wire
